// File: hdl/pekc_pkg.sv
// Package for the peak envelope hard knee compressor.
// Holds fixed widths, register index codes, conversion constants and the
// log2 routine used to build the conversion tables at elaboration.
`timescale 1ns / 1ps

package pekc_pkg;

    // Envelope is Q1.31 held in 32 bits; the shared multiplier's A port is one
    // bit wider so that it takes both unsigned envelope words and signed samples.
    localparam int ENV_WIDTH   = 32;
    localparam int MUL_A_WIDTH = ENV_WIDTH + 1;
    localparam int GAIN_WIDTH  = 17;
    localparam int NL_WIDTH    = 21;
    localparam int LZ_WIDTH    = 5;
    localparam int Q_WIDTH     = 21;
    localparam int ATT_WIDTH   = 17;

    localparam logic [GAIN_WIDTH-1:0] UNITY_GAIN = 17'h10000;

    // Leading zero search runs 16, 8, 4, 2 and 1 bit steps.
    localparam int NORM_STEPS = 5;

    // 20*log10(2) in Q.12, and log2(10)/20 scaled for Q8.8 dB to Q16 log2.
    localparam int DB_PER_LOG2 = 24660;
    localparam int LOG2_PER_DB = 43541;

    // Configuration register indexes.
    localparam int CFG_IDX_WIDTH = 3;
    typedef logic [CFG_IDX_WIDTH-1:0] t_cfg_index;
    localparam t_cfg_index CFG_THRESHOLD = 3'd0;
    localparam t_cfg_index CFG_ATTACK    = 3'd1;
    localparam t_cfg_index CFG_RELEASE   = 3'd2;
    localparam t_cfg_index CFG_SLOPE     = 3'd3;
    localparam t_cfg_index CFG_STEREO    = 3'd4;

    // log2 of a Q1.30 mantissa in [1,2), Q0.16, truncated, by repeated squaring.
    function automatic logic [15:0] lg(input logic [63:0] m_in);
        logic [63:0] m;
        logic [15:0] r;
        m = m_in;
        r = '0;
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            r = r << 1;
            if (m >= (64'd2 << 30)) begin
                r = r | 16'd1;
                m = m >> 1;
            end
        end
        return r;
    endfunction

    // Negative log2 of a Q0.16 gain from one half up, Q16; zero at unity and above.
    function automatic logic [16:0] neglog(input logic [16:0] x);
        if (x >= 17'h10000) begin
            return '0;
        end
        return 17'h10000 - 17'(lg(64'(x) << 15));
    endfunction

endpackage

// File: hdl/peak_envelope_hard_knee_compressor.sv
// Feed-forward peak compressor with a hard knee, one stereo frame per word.
// Depends on pekc_pkg for widths, register codes and the table log2 routine.
//
//   channel   dir  handshake                    payload
//   --------  ---  ---------------------------  ----------------------------------
//   config    in   i_cfg_wr_en                  i_cfg_index, i_cfg_wdata
//   frame in  in   i_in_valid / o_in_ready      i_left_in, i_right_in
//   frame out out  o_out_valid / i_out_ready    o_left_out, o_right_out,
//                                               o_applied_gain
//
// A frame steps through the sequencer states from one acceptance to the next,
// adding the gain states when gain reduction applies. The sequence is set by
// the one shared multiplier, which carries every product in turn, and by the
// five-step leading zero search on the envelope. A result waits in the output
// register while the next frame is taken; a result that finds that register
// still full holds the sequencer in its last step until it frees. Reset is
// synchronous and restores state, configuration and a zero envelope.
`timescale 1ns / 1ps

module peak_envelope_hard_knee_compressor #(
    parameter int SAMPLE_WIDTH     = 24,
    parameter int COEFF_WIDTH      = 16,
    parameter int CONV_TABLE_DEPTH = 256,
    localparam int CFG_WIDTH = (COEFF_WIDTH > 16) ? COEFF_WIDTH : 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [pekc_pkg::CFG_IDX_WIDTH-1:0]   i_cfg_index,
    input  logic [CFG_WIDTH-1:0]                 i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]       i_left_in,
    input  logic signed [SAMPLE_WIDTH-1:0]       i_right_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]       o_left_out,
    output logic signed [SAMPLE_WIDTH-1:0]       o_right_out,
    output logic [pekc_pkg::GAIN_WIDTH-1:0]      o_applied_gain
);

    localparam int IW        = $clog2(CONV_TABLE_DEPTH);
    localparam int AW        = pekc_pkg::MUL_A_WIDTH;
    localparam int BW        = (COEFF_WIDTH + 2 > 18) ? COEFF_WIDTH + 2 : 18;
    localparam int PW        = AW + BW;
    localparam int EW        = pekc_pkg::ENV_WIDTH;
    localparam int GW        = pekc_pkg::GAIN_WIDTH;
    localparam int KEY_SHIFT = EW - SAMPLE_WIDTH;

    typedef logic [15:0]   t_log_tab [CONV_TABLE_DEPTH];
    typedef logic [GW-1:0] t_exp_tab [CONV_TABLE_DEPTH];

    // log2 of the mantissa at each table point, Q0.16.
    function automatic t_log_tab build_log_tab();
        t_log_tab tab;
        for (int k = 0; k < CONV_TABLE_DEPTH; k++) begin
            tab[k] = pekc_pkg::lg((64'd1 << 30) + ((64'(k) << 30) / CONV_TABLE_DEPTH));
        end
        return tab;
    endfunction

    // Smallest gain whose negative log2 does not exceed each table point.
    function automatic t_exp_tab build_exp_tab();
        t_exp_tab    tab;
        logic [16:0] lo;
        logic [16:0] hi;
        logic [16:0] mid;
        logic [16:0] t;
        for (int k = 0; k < CONV_TABLE_DEPTH; k++) begin
            t  = 17'((64'(k) << 16) / CONV_TABLE_DEPTH);
            lo = 17'd32768;
            hi = 17'h10000;
            while (lo < hi) begin
                mid = 17'((18'(lo) + 18'(hi)) >> 1);
                if (pekc_pkg::neglog(mid) <= t) begin
                    hi = mid;
                end else begin
                    lo = mid + 17'd1;
                end
            end
            tab[k] = lo;
        end
        return tab;
    endfunction

    localparam t_log_tab LOG_TAB = build_log_tab();
    localparam t_exp_tab EXP_TAB = build_exp_tab();

    typedef enum logic [17:0] {
        S_IDLE = 18'b000000000000000001,
        S_ENV0 = 18'b000000000000000010,
        S_ENV1 = 18'b000000000000000100,
        S_ENV2 = 18'b000000000000001000,
        S_NORM = 18'b000000000000010000,
        S_IDX  = 18'b000000000000100000,
        S_LOG  = 18'b000000000001000000,
        S_DB   = 18'b000000000010000000,
        S_EXC  = 18'b000000000100000000,
        S_ATT  = 18'b000000001000000000,
        S_ATTR = 18'b000000010000000000,
        S_Q    = 18'b000000100000000000,
        S_QR   = 18'b000001000000000000,
        S_FI   = 18'b000010000000000000,
        S_GAIN = 18'b000100000000000000,
        S_SCL0 = 18'b001000000000000000,
        S_SCL1 = 18'b010000000000000000,
        S_SCL2 = 18'b100000000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Configuration registers.
    logic signed [15:0]      r_threshold;
    logic [COEFF_WIDTH-1:0]  r_attack;
    logic [COEFF_WIDTH-1:0]  r_release;
    logic signed [15:0]      r_gain_slope;
    logic                    r_stereo_on;

    // Datapath registers.
    logic [EW-1:0]                    r_env;
    logic [EW-1:0]                    n_env;
    logic signed [SAMPLE_WIDTH-1:0]   r_l;
    logic signed [SAMPLE_WIDTH-1:0]   r_r;
    logic [EW-1:0]                    r_key;
    logic [COEFF_WIDTH-1:0]           r_coef;
    logic signed [PW-1:0]             r_acc;
    logic signed [PW-1:0]             r_prod;
    logic [EW-1:0]                    r_norm;
    logic [pekc_pkg::LZ_WIDTH-1:0]    r_lz;
    logic [2:0]                       r_step;
    logic                             r_zero;
    logic [pekc_pkg::NL_WIDTH-1:0]    r_nl;
    logic signed [17:0]               r_exc;
    logic [pekc_pkg::ATT_WIDTH-1:0]   r_att;
    logic [pekc_pkg::Q_WIDTH-1:0]     r_q;
    logic [GW-1:0]                    r_gain;
    logic signed [SAMPLE_WIDTH-1:0]   r_lout;

    // Shared multiplier operands.
    logic                  mul_en;
    logic signed [AW-1:0]  mul_a;
    logic signed [BW-1:0]  mul_b;

    logic [SAMPLE_WIDTH-1:0]  mag_l;
    logic [SAMPLE_WIDTH-1:0]  mag_r;
    logic [SAMPLE_WIDTH-1:0]  key_mag;
    logic [EW-1:0]            in_key;
    logic [COEFF_WIDTH-1:0]   coef_sel;
    logic [COEFF_WIDTH:0]     coef_comp;
    logic [PW:0]              env_sum;
    logic [4:0]               norm_shift;
    logic                     norm_top_zero;
    logic [IW-1:0]            log_idx;
    logic [IW-1:0]            exp_idx;
    logic [16:0]              db_mag;
    logic signed [17:0]       excess;
    logic signed [16:0]       neg_slope;
    logic                     compress;
    logic [4:0]               gain_shift;
    logic signed [SAMPLE_WIDTH-1:0] scaled;
    logic                     out_free;
    logic                     in_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign out_free   = !o_out_valid || i_out_ready;

    // Frame key: larger magnitude, left only in mono, moved up to Q1.31.
    assign mag_l   = i_left_in[SAMPLE_WIDTH-1] ? (~i_left_in + 1'b1) : i_left_in;
    assign mag_r   = i_right_in[SAMPLE_WIDTH-1] ? (~i_right_in + 1'b1) : i_right_in;
    assign key_mag = (r_stereo_on && (mag_r > mag_l)) ? mag_r : mag_l;
    assign in_key  = EW'(key_mag) << KEY_SHIFT;

    // Envelope follower pole and its complement.
    assign coef_sel  = (r_key > r_env) ? r_attack : r_release;
    assign coef_comp = {1'b1, {COEFF_WIDTH{1'b0}}} - {1'b0, r_coef};
    assign env_sum   = {1'b0, r_acc} + {1'b0, r_prod} + ((PW + 1)'(1) << (COEFF_WIDTH - 1));
    assign n_env     = env_sum[COEFF_WIDTH +: EW];

    // Leading zero search step.
    assign norm_shift    = 5'd16 >> r_step;
    assign norm_top_zero = (r_norm >> (6'd32 - {1'b0, norm_shift})) == '0;

    // Table indexes come from the scaled fraction in the product register.
    assign log_idx = r_prod[30 +: IW];
    assign exp_idx = r_prod[16 +: IW];

    // Envelope in dB and its excess over the threshold.
    assign db_mag    = 17'((r_prod + PW'(1 << 19)) >>> 20);
    assign excess    = 18'(-$signed({1'b0, db_mag})) - 18'(r_threshold);
    assign neg_slope = -17'(r_gain_slope);
    assign compress  = !r_zero && (excess > 0) && (r_gain_slope < 0);

    assign gain_shift = r_q[pekc_pkg::Q_WIDTH-1:16];
    assign scaled     = SAMPLE_WIDTH'((r_prod + PW'(32768)) >>> 16);

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (r_state)
            S_ENV0: begin
                mul_a = AW'(r_env);
                mul_b = BW'(coef_sel);
            end
            S_ENV1: begin
                mul_a = AW'(r_key);
                mul_b = BW'(coef_comp);
            end
            S_IDX: begin
                mul_a = AW'(r_norm[30:1]);
                mul_b = BW'(CONV_TABLE_DEPTH);
            end
            S_DB: begin
                mul_a = AW'(r_nl);
                mul_b = BW'(pekc_pkg::DB_PER_LOG2);
            end
            S_ATT: begin
                mul_a = AW'(r_exc);
                mul_b = BW'(neg_slope);
            end
            S_Q: begin
                mul_a = AW'(r_att);
                mul_b = BW'(pekc_pkg::LOG2_PER_DB);
            end
            S_FI: begin
                mul_a = AW'(r_q[15:0]);
                mul_b = BW'(CONV_TABLE_DEPTH);
            end
            S_SCL0: begin
                mul_a = AW'(r_l);
                mul_b = BW'(r_gain);
            end
            S_SCL1: begin
                mul_a = AW'(r_r);
                mul_b = BW'(r_gain);
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_ENV0;
            S_ENV0: n_state = S_ENV1;
            S_ENV1: n_state = S_ENV2;
            S_ENV2: n_state = S_NORM;
            S_NORM: if (r_step == 3'(pekc_pkg::NORM_STEPS - 1)) n_state = S_IDX;
            S_IDX:  n_state = S_LOG;
            S_LOG:  n_state = S_DB;
            S_DB:   n_state = S_EXC;
            S_EXC:  n_state = compress ? S_ATT : S_SCL0;
            S_ATT:  n_state = S_ATTR;
            S_ATTR: n_state = S_Q;
            S_Q:    n_state = S_QR;
            S_QR:   n_state = S_FI;
            S_FI:   n_state = S_GAIN;
            S_GAIN: n_state = S_SCL0;
            S_SCL0: n_state = S_SCL1;
            S_SCL1: n_state = S_SCL2;
            S_SCL2: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state, configuration, envelope and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_threshold  <= -16'sd3072;
            r_attack     <= COEFF_WIDTH'(65000);
            r_release    <= COEFF_WIDTH'(65500);
            r_gain_slope <= -16'sd24576;
            r_stereo_on  <= 1'b1;
            r_env        <= '0;
            o_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    pekc_pkg::CFG_THRESHOLD: r_threshold  <= i_cfg_wdata[15:0];
                    pekc_pkg::CFG_ATTACK:    r_attack     <= i_cfg_wdata[COEFF_WIDTH-1:0];
                    pekc_pkg::CFG_RELEASE:   r_release    <= i_cfg_wdata[COEFF_WIDTH-1:0];
                    pekc_pkg::CFG_SLOPE:     r_gain_slope <= i_cfg_wdata[15:0];
                    pekc_pkg::CFG_STEREO:    r_stereo_on  <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (r_state == S_ENV2) begin
                r_env <= n_env;
            end
            if ((r_state == S_SCL2) && out_free) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // Shared multiplier with its registered product.
    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
    end

    // Datapath registers, loaded step by step.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    r_l   <= i_left_in;
                    r_r   <= i_right_in;
                    r_key <= in_key;
                end
            end
            S_ENV0: r_coef <= coef_sel;
            S_ENV1: r_acc  <= r_prod;
            S_ENV2: begin
                r_norm <= n_env;
                r_lz   <= '0;
                r_step <= '0;
                r_zero <= (n_env == '0);
            end
            S_NORM: begin
                if (norm_top_zero) begin
                    r_norm <= r_norm << norm_shift;
                    r_lz   <= r_lz + norm_shift;
                end
                r_step <= r_step + 3'd1;
            end
            S_LOG: begin
                r_nl <= {r_lz, 16'd0} - pekc_pkg::NL_WIDTH'(LOG_TAB[log_idx]);
            end
            S_EXC: begin
                r_exc <= excess;
                if (!compress) begin
                    r_gain <= pekc_pkg::UNITY_GAIN;
                end
            end
            S_ATTR: r_att <= pekc_pkg::ATT_WIDTH'((r_prod + PW'(1 << 14)) >>> 15);
            S_QR:   r_q   <= pekc_pkg::Q_WIDTH'((r_prod + PW'(512)) >>> 10);
            S_GAIN: begin
                if (gain_shift >= 5'd17) begin
                    r_gain <= '0;
                end else begin
                    r_gain <= EXP_TAB[exp_idx] >> gain_shift;
                end
            end
            S_SCL1: r_lout <= scaled;
            default: ;
        endcase
    end

    // Output register, loaded once the last product is in.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_SCL2) && out_free) begin
            o_left_out     <= r_lout;
            o_right_out    <= r_stereo_on ? scaled : '0;
            o_applied_gain <= r_gain;
        end
    end

    // The envelope is an average of keys no larger than full scale.
    a_env_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_env <= 32'h8000_0000)
        else $error("envelope above full scale");

    // After the last search step a nonzero envelope is normalized.
    a_norm_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NORM) && (r_step == 3'(pekc_pkg::NORM_STEPS - 1)) && !r_zero
        |=> r_norm[EW-1])
        else $error("normalizer left a leading zero");

    // A zero envelope always yields unity gain.
    a_zero_unity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXC) && r_zero |=> r_gain == pekc_pkg::UNITY_GAIN)
        else $error("zero envelope without unity gain");

    // The gain never exceeds unity on a delivered word.
    a_gain_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_applied_gain <= pekc_pkg::UNITY_GAIN)
        else $error("applied gain above unity");

    // In mono the right output is loaded as zero.
    a_mono_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCL2) && out_free && !r_stereo_on |=> o_right_out == '0)
        else $error("right output nonzero in mono");

endmodule
